// ===== hw/rtl/odo_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Odometry package
// Shared types, fixed-point constants and saturation helpers for the
// differential-drive odometry block.
// ----------------------------------------------------------------------------
package odo_pkg;

	typedef enum logic [1:0] {
		OP_POS,
		OP_LEFT,
		OP_RIGHT,
		OP_CLEAR
	} op_t;

	localparam logic [1:0] REG_MM_PER_TICK = 2'd0;
	localparam logic [1:0] REG_AXIS        = 2'd1;
	localparam logic [1:0] REG_HALF_AXIS   = 2'd2;

	localparam logic [31:0] MM_PER_TICK_RST = 32'd65536;

	// Angles in Q3.30.
	localparam logic [32:0] TWO_PI_Q30  = 33'd6746518852;
	localparam logic [32:0] PI_Q30      = 33'd3373259426;
	localparam logic [32:0] HALF_PI_Q30 = 33'd1686629713;
	localparam logic [33:0] GAIN_Q30    = 34'd652032874;

	localparam logic [31:0] DEG_MUL     = 32'd4068;
	localparam logic [31:0] DEG_FRAC    = 32'd60492467;

	localparam logic [29:0] ATAN_Q30 [32] = '{
		30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
		30'd33543515, 30'd16775850, 30'd8388437, 30'd4194282, 30'd2097149,
		30'd1048575, 30'd524287, 30'd262143, 30'd131071, 30'd65535, 30'd32767,
		30'd16383, 30'd8191, 30'd4095, 30'd2047, 30'd1023, 30'd511, 30'd255,
		30'd127, 30'd63, 30'd31, 30'd15, 30'd8, 30'd4, 30'd2, 30'd1, 30'd0
	};

	// Where the product is cut and rounded.
	typedef enum logic [1:0] {
		SH_NONE,
		SH_32,
		SH_52
	} mac_shift_t;

	typedef struct packed {
		logic       neg;
		logic [63:0] a_mag;
		logic [31:0] b_mag;
		mac_shift_t shift;
	} mac_req_t;

	function automatic logic [63:0] mag64(input logic signed [65:0] v);
		logic signed [65:0] n;
		n = -v;
		return v[65] ? n[63:0] : v[63:0];
	endfunction

	function automatic logic signed [47:0] sat48(input logic signed [65:0] v);
		if ((&v[65:47]) || !(|v[65:47])) begin
			return v[47:0];
		end
		return v[65] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		if ((&v[65:31]) || !(|v[65:31])) begin
			return v[31:0];
		end
		return v[65] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
	endfunction

	function automatic logic signed [17:0] sat18(input logic signed [65:0] v);
		if ((&v[65:17]) || !(|v[65:17])) begin
			return v[17:0];
		end
		return v[65] ? {1'b1, 17'd0} : {1'b0, {17{1'b1}}};
	endfunction

endpackage

// ===== hw/rtl/odo_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Odometry channel interfaces
// Sample, result and register-write channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface odo_sample_if;
	logic               valid;
	logic               ready;
	logic [1:0]         opcode;
	logic signed [31:0] left_ticks;
	logic signed [31:0] right_ticks;

	modport source (output valid, opcode, left_ticks, right_ticks, input ready);
	modport sink   (input valid, opcode, left_ticks, right_ticks, output ready);
endinterface

interface odo_result_if;
	logic               valid;
	logic               ready;
	logic signed [47:0] x_pos;
	logic signed [47:0] y_pos;
	logic signed [17:0] heading_deg;

	modport source (output valid, x_pos, y_pos, heading_deg, input ready);
	modport sink   (input valid, x_pos, y_pos, heading_deg, output ready);
endinterface

interface odo_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [31:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/diff_drive_odometry_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Differential-drive odometry
// Tracks position and heading from cumulative wheel encoder counts.
// ----------------------------------------------------------------------------
// Usage. The sample channel takes one word per encoder reading: an opcode
// and the cumulative left and right counts. Each sample word gives exactly
// one result word on the result channel: x and y in Q32.16 millimetres and
// the last rounded heading in whole degrees. The cfg channel writes the
// scale registers (index 0 mm per tick, 1 axis factor, 2 half-axis factor;
// index 3 is ignored) and is always ready; write it only while idle.
// Timing. One sample at a time, with sample ready low meanwhile. Each step
// uses one shared 32x32 multiplier or a CORDIC. A position update runs the
// steps DL, DR, HEAD, CORDIC, XINC and YINC, a turn update DL, DR, TURN,
// DEG1 and DEG2, and a clear goes straight to the hand-over; sample ready
// returns in the same cycle as the result word appears.
// The result sits in an output register, so a stalled receiver does not
// hold up the next sample; only when a second result is ready while the
// first is still waiting does the sequencer pause.
// Reset clears the position, heading, stored counts and registers to their
// defaults at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module diff_drive_odometry_top #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	odo_sample_if.sink          sample,
	odo_result_if.source        result,
	odo_cfg_if.sink             cfg
);

	// Sequencer steps. Each multiply step issues one request to the shared
	// unit and waits for it to come back.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DL,
		ST_DR,
		ST_HEAD,
		ST_CORDIC,
		ST_XINC,
		ST_YINC,
		ST_TURN,
		ST_DEG1,
		ST_DEG2,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   pending_q;

	// Scale registers.
	logic [31:0] mm_q;
	logic [31:0] axis_q;
	logic [31:0] half_q;

	// Odometry state.
	logic [31:0]        last_left_q;
	logic [31:0]        last_right_q;
	logic signed [47:0] pos_x_q;
	logic signed [47:0] pos_y_q;
	logic signed [31:0] head_q;
	logic signed [17:0] deg_q;

	// Working values of the sample in flight.
	odo_pkg::op_t       op_q;
	logic signed [31:0] dlt_l_q;
	logic signed [31:0] dlt_r_q;
	logic signed [47:0] dl_q;
	logic signed [47:0] dr_q;
	logic signed [47:0] mean_q;
	logic signed [33:0] cos_q;
	logic signed [33:0] sin_q;
	logic [63:0]        deg_mag_q;

	// Result register.
	logic               out_valid_q;
	logic signed [47:0] out_x_q;
	logic signed [47:0] out_y_q;
	logic signed [17:0] out_deg_q;

	logic               accept;
	logic               mac_state;
	logic               mac_start;
	logic               mac_done;
	logic signed [65:0] mac_res;
	odo_pkg::mac_req_t  mac_req;
	logic               cor_start;
	logic               cor_done;
	logic signed [33:0] cor_cos;
	logic signed [33:0] cor_sin;

	logic signed [65:0] diff;
	logic signed [48:0] wsum;
	logic signed [47:0] turn_dist;
	logic signed [31:0] hd;
	logic signed [31:0] head_new;
	logic signed [47:0] pinc;

	assign accept = sample.valid && sample.ready;

	always_comb begin
		diff      = 66'(dr_q) - 66'(dl_q);
		wsum      = 49'(dl_q) + 49'(dr_q);
		turn_dist = (op_q == odo_pkg::OP_LEFT) ? dr_q : dl_q;
		hd        = odo_pkg::sat32(mac_res);
		head_new  = odo_pkg::sat32(66'(head_q) + 66'(hd));
		pinc      = odo_pkg::sat48(mac_res);
	end

	// Operands for the shared multiplier, chosen by the sequencer step.
	always_comb begin
		mac_state     = 1'b1;
		mac_req.neg   = 1'b0;
		mac_req.a_mag = '0;
		mac_req.b_mag = '0;
		mac_req.shift = odo_pkg::SH_NONE;
		unique case (state_q)
			ST_DL: begin
				mac_req.neg   = dlt_l_q[31];
				mac_req.a_mag = odo_pkg::mag64(66'(dlt_l_q));
				mac_req.b_mag = mm_q;
			end
			ST_DR: begin
				mac_req.neg   = dlt_r_q[31];
				mac_req.a_mag = odo_pkg::mag64(66'(dlt_r_q));
				mac_req.b_mag = mm_q;
			end
			ST_HEAD: begin
				mac_req.neg   = diff[65];
				mac_req.a_mag = odo_pkg::mag64(diff) << 4;
				mac_req.b_mag = axis_q;
				mac_req.shift = odo_pkg::SH_32;
			end
			ST_TURN: begin
				mac_req.neg   = turn_dist[47];
				mac_req.a_mag = odo_pkg::mag64(66'(turn_dist)) << 4;
				mac_req.b_mag = half_q;
				mac_req.shift = odo_pkg::SH_32;
			end
			ST_XINC: begin
				mac_req.neg   = mean_q[47] ^ cos_q[33];
				mac_req.a_mag = odo_pkg::mag64(66'(mean_q)) << 2;
				mac_req.b_mag = 32'(odo_pkg::mag64(66'(cos_q)));
				mac_req.shift = odo_pkg::SH_32;
			end
			ST_YINC: begin
				mac_req.neg   = mean_q[47] ^ sin_q[33];
				mac_req.a_mag = odo_pkg::mag64(66'(mean_q)) << 2;
				mac_req.b_mag = 32'(odo_pkg::mag64(66'(sin_q)));
				mac_req.shift = odo_pkg::SH_32;
			end
			ST_DEG1: begin
				mac_req.a_mag = odo_pkg::mag64(66'(head_q));
				mac_req.b_mag = odo_pkg::DEG_MUL;
			end
			ST_DEG2: begin
				mac_req.neg   = head_q[31];
				mac_req.a_mag = deg_mag_q;
				mac_req.b_mag = odo_pkg::DEG_FRAC;
				mac_req.shift = odo_pkg::SH_52;
			end
			default: mac_state = 1'b0;
		endcase
	end

	assign mac_start = mac_state && !pending_q;
	assign cor_start = (state_q == ST_CORDIC) && !pending_q;

	odo_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mac_start),
		.req    (mac_req),
		.done   (mac_done),
		.res    (mac_res)
	);

	odo_cordic #(
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cor_start),
		.heading (head_q),
		.done    (cor_done),
		.cos_val (cor_cos),
		.sin_val (cor_sin)
	);

	// Sequencer, odometry state and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			pending_q    <= 1'b0;
			mm_q         <= odo_pkg::MM_PER_TICK_RST;
			axis_q       <= '0;
			half_q       <= '0;
			last_left_q  <= '0;
			last_right_q <= '0;
			pos_x_q      <= '0;
			pos_y_q      <= '0;
			head_q       <= '0;
			deg_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg.valid) begin
				unique case (cfg.index)
					odo_pkg::REG_MM_PER_TICK: mm_q   <= cfg.data;
					odo_pkg::REG_AXIS:        axis_q <= cfg.data;
					odo_pkg::REG_HALF_AXIS:   half_q <= cfg.data;
					default: ;
				endcase
			end

			if (out_valid_q && result.ready) begin
				out_valid_q <= 1'b0;
			end

			if (mac_start || cor_start) begin
				pending_q <= 1'b1;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (odo_pkg::op_t'(sample.opcode) == odo_pkg::OP_CLEAR) begin
							last_left_q  <= '0;
							last_right_q <= '0;
							pos_x_q      <= '0;
							pos_y_q      <= '0;
							head_q       <= '0;
							deg_q        <= '0;
							state_q      <= ST_DONE;
						end else begin
							last_left_q  <= sample.left_ticks;
							last_right_q <= sample.right_ticks;
							state_q      <= ST_DL;
						end
					end
				end
				ST_DL: if (mac_done) begin
					pending_q <= 1'b0;
					state_q   <= ST_DR;
				end
				ST_DR: if (mac_done) begin
					pending_q <= 1'b0;
					state_q   <= (op_q == odo_pkg::OP_POS) ? ST_HEAD : ST_TURN;
				end
				ST_HEAD: if (mac_done) begin
					pending_q <= 1'b0;
					head_q    <= head_new;
					state_q   <= ST_CORDIC;
				end
				ST_CORDIC: if (cor_done) begin
					pending_q <= 1'b0;
					state_q   <= ST_XINC;
				end
				ST_XINC: if (mac_done) begin
					pending_q <= 1'b0;
					pos_x_q   <= odo_pkg::sat48(66'(pos_x_q) + 66'(pinc));
					state_q   <= ST_YINC;
				end
				ST_YINC: if (mac_done) begin
					pending_q <= 1'b0;
					pos_y_q   <= odo_pkg::sat48(66'(pos_y_q) + 66'(pinc));
					state_q   <= ST_DONE;
				end
				ST_TURN: if (mac_done) begin
					pending_q <= 1'b0;
					head_q    <= head_new;
					pos_y_q   <= odo_pkg::sat48(diff);
					state_q   <= ST_DEG1;
				end
				ST_DEG1: if (mac_done) begin
					pending_q <= 1'b0;
					state_q   <= ST_DEG2;
				end
				ST_DEG2: if (mac_done) begin
					pending_q <= 1'b0;
					deg_q     <= odo_pkg::sat18(mac_res);
					state_q   <= ST_DONE;
				end
				ST_DONE: begin
					// Hand over once the result register is free or being emptied.
					if (!out_valid_q || result.ready) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Working values and result payload carry no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= odo_pkg::op_t'(sample.opcode);
			dlt_l_q <= $signed(sample.left_ticks - last_left_q);
			dlt_r_q <= $signed(sample.right_ticks - last_right_q);
		end
		if (state_q == ST_DL && mac_done) begin
			dl_q <= odo_pkg::sat48(mac_res);
		end
		if (state_q == ST_DR && mac_done) begin
			dr_q <= odo_pkg::sat48(mac_res);
		end
		if (state_q == ST_HEAD && mac_done) begin
			mean_q <= wsum[48:1];
		end
		if (state_q == ST_CORDIC && cor_done) begin
			cos_q <= cor_cos;
			sin_q <= cor_sin;
		end
		if (state_q == ST_DEG1 && mac_done) begin
			deg_mag_q <= odo_pkg::mag64(mac_res);
		end
		if (state_q == ST_DONE && (!out_valid_q || result.ready)) begin
			out_x_q   <= pos_x_q;
			out_y_q   <= pos_y_q;
			out_deg_q <= deg_q;
		end
	end

	assign sample.ready       = (state_q == ST_IDLE);
	assign cfg.ready          = 1'b1;
	assign result.valid       = out_valid_q;
	assign result.x_pos       = out_x_q;
	assign result.y_pos       = out_y_q;
	assign result.heading_deg = out_deg_q;

endmodule

// ===== hw/rtl/odo_mac.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Odometry multiply unit
// One 32x32 multiplier, used twice per request to build a 64x32 product,
// then cut and rounded half away from zero where a shift is selected, and signed.
// ----------------------------------------------------------------------------
module odo_mac (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  odo_pkg::mac_req_t  req,
	output logic               done,
	output logic signed [65:0] res
);

	typedef enum logic [1:0] {
		MP_IDLE,
		MP_LOW,
		MP_HIGH,
		MP_ROUND
	} phase_t;

	phase_t             phase_q;
	logic               done_q;
	odo_pkg::mac_req_t  req_q;
	logic [95:0]        acc_q;
	logic signed [65:0] res_q;

	logic [31:0] mul_a;
	logic [63:0] prod;
	logic [64:0] rnd;

	always_comb begin
		mul_a = (phase_q == MP_HIGH) ? req_q.a_mag[63:32] : req_q.a_mag[31:0];
		prod  = 64'(mul_a) * 64'(req_q.b_mag);
		unique case (req_q.shift)
			odo_pkg::SH_32: rnd = 65'(acc_q[95:32]) + 65'(acc_q[31]);
			odo_pkg::SH_52: rnd = 65'(acc_q[95:52]) + 65'(acc_q[51]);
			default:        rnd = acc_q[64:0];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= MP_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (phase_q)
				MP_IDLE:  if (start) phase_q <= MP_LOW;
				MP_LOW:   phase_q <= MP_HIGH;
				MP_HIGH:  phase_q <= MP_ROUND;
				MP_ROUND: begin
					done_q  <= 1'b1;
					phase_q <= MP_IDLE;
				end
				default:  phase_q <= MP_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (phase_q == MP_IDLE && start) begin
			req_q <= req;
		end
		if (phase_q == MP_LOW) begin
			acc_q <= 96'(prod);
		end
		if (phase_q == MP_HIGH) begin
			acc_q <= acc_q + {prod, 32'd0};
		end
		if (phase_q == MP_ROUND) begin
			res_q <= req_q.neg ? -$signed({1'b0, rnd}) : $signed({1'b0, rnd});
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

// ===== hw/rtl/odo_cordic.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Odometry CORDIC
// Reduces a Q12.20 heading modulo two pi by shifted subtraction, folds it
// into the right half plane and rotates one step per cycle.
// ----------------------------------------------------------------------------
module odo_cordic #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [31:0] heading,
	output logic               done,
	output logic signed [33:0] cos_val,
	output logic signed [33:0] sin_val
);

	localparam int CW = $clog2(CORDIC_STEPS + 1);

	typedef enum logic [1:0] {
		CS_IDLE,
		CS_REDUCE,
		CS_FOLD,
		CS_ROTATE
	} cstate_t;

	cstate_t            state_q;
	logic               done_q;
	logic [3:0]         k_q;
	logic [CW-1:0]      i_q;
	logic [41:0]        mag_q;
	logic               neg_q;
	logic signed [34:0] z_q;
	logic signed [33:0] x_q;
	logic signed [33:0] y_q;
	logic               flip_q;

	logic signed [41:0] z_in;
	logic signed [41:0] z_in_neg;
	logic [42:0]        sub;
	logic signed [34:0] zs;
	logic signed [34:0] z1;
	logic signed [34:0] z2;
	logic               flip;
	logic signed [33:0] dx;
	logic signed [33:0] dy;
	logic signed [34:0] atan_i;

	always_comb begin
		z_in     = {heading, 10'd0};
		z_in_neg = -z_in;
		sub      = 43'(odo_pkg::TWO_PI_Q30) << k_q;
		zs       = neg_q ? -$signed(35'(mag_q[33:0])) : $signed(35'(mag_q[33:0]));
		if (zs > $signed(35'(odo_pkg::PI_Q30))) begin
			z1 = zs - $signed(35'(odo_pkg::TWO_PI_Q30));
		end else if (zs < -$signed(35'(odo_pkg::PI_Q30))) begin
			z1 = zs + $signed(35'(odo_pkg::TWO_PI_Q30));
		end else begin
			z1 = zs;
		end
		flip = 1'b1;
		if (z1 > $signed(35'(odo_pkg::HALF_PI_Q30))) begin
			z2 = z1 - $signed(35'(odo_pkg::PI_Q30));
		end else if (z1 < -$signed(35'(odo_pkg::HALF_PI_Q30))) begin
			z2 = z1 + $signed(35'(odo_pkg::PI_Q30));
		end else begin
			z2   = z1;
			flip = 1'b0;
		end
		dx     = y_q >>> i_q;
		dy     = x_q >>> i_q;
		atan_i = $signed(35'(odo_pkg::ATAN_Q30[5'(i_q)]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				CS_IDLE:   if (start) state_q <= CS_REDUCE;
				CS_REDUCE: if (k_q == 4'd0) state_q <= CS_FOLD;
				CS_FOLD:   state_q <= CS_ROTATE;
				CS_ROTATE: if (i_q == CW'(CORDIC_STEPS - 1)) begin
					done_q  <= 1'b1;
					state_q <= CS_IDLE;
				end
				default:   state_q <= CS_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			CS_IDLE: begin
				k_q   <= 4'd9;
				neg_q <= heading[31];
				mag_q <= heading[31] ? z_in_neg : z_in;
			end
			CS_REDUCE: begin
				if ({1'b0, mag_q} >= sub) begin
					mag_q <= 42'({1'b0, mag_q} - sub);
				end
				k_q <= k_q - 4'd1;
			end
			CS_FOLD: begin
				z_q    <= z2;
				flip_q <= flip;
				x_q    <= $signed(odo_pkg::GAIN_Q30);
				y_q    <= '0;
				i_q    <= '0;
			end
			CS_ROTATE: begin
				if (!z_q[34]) begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
					z_q <= z_q - atan_i;
				end else begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
					z_q <= z_q + atan_i;
				end
				i_q <= i_q + CW'(1);
			end
			default: ;
		endcase
	end

	assign done    = done_q;
	assign cos_val = flip_q ? -x_q : x_q;
	assign sin_val = flip_q ? -y_q : y_q;

endmodule

// ===== hw/rtl/odo_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Odometry port checker
// Watches the top-level channels of the odometry block over time.
// ----------------------------------------------------------------------------
module odo_checker (
	input logic clk,
	input logic arst_n,
	input logic s_valid,
	input logic s_ready,
	input logic r_valid,
	input logic r_ready,
	input logic c_ready
);

	// A sample keeps the block busy for at least the following cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_valid && s_ready) |=> !s_ready)
		else $error("sample ready held after an accepted word");

	// A new result only appears while the block is busy with a sample.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(r_valid) |-> $past(!s_ready))
		else $error("result appeared without a sample in progress");

	// A waiting result is not withdrawn.
	assert property (@(posedge clk) disable iff (!arst_n)
		(r_valid && !r_ready) |=> r_valid)
		else $error("result withdrawn while stalled");

	// Register writes are never back-pressured.
	assert property (@(posedge clk) disable iff (!arst_n)
		c_ready)
		else $error("register write channel not ready");

endmodule

bind diff_drive_odometry_top odo_checker u_odo_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_valid (sample.valid),
	.s_ready (sample.ready),
	.r_valid (result.valid),
	.r_ready (result.ready),
	.c_ready (cfg.ready)
);
